// File: hdl/jcd_pkg.sv
// Shared types, register indexes and field widths for the joystick conditioning block.
// No dependencies.
package jcd_pkg;

	localparam int AxisW = 8;
	localparam int RemapW = 48;
	localparam int DivW = 7;

	typedef enum logic [2:0] {
		REG_FLAGS = 3'd0,
		REG_REMAP_L = 3'd1,
		REG_REMAP_R = 3'd2,
		REG_DZ_L = 3'd3,
		REG_DZ_R = 3'd4,
		REG_TH_L = 3'd5,
		REG_TH_R = 3'd6
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_DIGITAL = 2'd0,
		MODE_ANALOG = 2'd1,
		MODE_ANALOG_FULL = 2'd2,
		MODE_OTHER = 2'd3
	} mode_t;

	// divider step payload: partial remainder, quotient bits, operand info
	typedef struct packed {
		logic [15:0] rem;
		logic [15:0] den;
		logic [6:0] quo;
		logic force_max;
		logic force_zero;
		logic upper;
	} div_t;

endpackage

// File: hdl/joystick_calibrate_deadzone.sv
// Joystick conditioning: remap, deadzone and stick-to-button mapping.
// Registered output after the divider pipe; one item per cycle while the output is not stalled.
// Eight divider stages per axis set the depth; a stall freezes the whole pipe.
// arst_n clears valid bits and configuration registers.
// Depends on jcd_pkg and jcd_axis.
module joystick_calibrate_deadzone import jcd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [47:0] cfg_data,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [39:0] s_axis_tdata, // lx, ly, rx, ry, buttons
	input logic [1:0] s_axis_tuser, // mode
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [39:0] m_axis_tdata // lx, ly, rx, ry, buttons
);

	localparam int Depth = DivW + 1;

	logic [3:0] flags_q;
	logic [47:0] rl_q, rr_q;
	logic [7:0] dzl_q, dzr_q, thl_q, thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0; rl_q <= '0; rr_q <= '0;
			dzl_q <= '0; dzr_q <= '0; thl_q <= '0; thr_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FLAGS: flags_q <= cfg_data[3:0];
				REG_REMAP_L: rl_q <= cfg_data;
				REG_REMAP_R: rr_q <= cfg_data;
				REG_DZ_L: dzl_q <= cfg_data[7:0];
				REG_DZ_R: dzr_q <= cfg_data[7:0];
				REG_TH_L: thl_q <= cfg_data[7:0];
				REG_TH_R: thr_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	logic [Depth-1:0] vld_s1;
	logic adv;
	logic [7:0] btn_s1 [Depth];
	logic [7:0] lx, ly, rx, ry, b;
	logic analog, rmp;
	logic [7:0] ox [4];

	assign lx = s_axis_tdata[7:0];
	assign ly = s_axis_tdata[15:8];
	assign rx = s_axis_tdata[23:16];
	assign ry = s_axis_tdata[31:24];
	assign analog = flags_q[0] && (s_axis_tuser == MODE_ANALOG || s_axis_tuser == MODE_ANALOG_FULL);
	assign rmp = flags_q[1];

	assign adv = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;

	function automatic logic [3:0] map4(input logic [7:0] x, input logic [7:0] y,
			input logic [7:0] t);
		logic signed [9:0] xs, ys, lo, hi;
		xs = $signed({2'b00, x});
		ys = $signed({2'b00, y});
		lo = 10'sd127 - $signed({2'b00, t});
		hi = 10'sd128 + $signed({2'b00, t});
		map4 = {ys > hi, ys < lo, xs > hi, xs < lo};
	endfunction

	always_comb begin
		b = s_axis_tdata[39:32];
		if (flags_q[0] && s_axis_tuser == MODE_DIGITAL) begin
			if (flags_q[2]) b[3:0] = b[3:0] & ~map4(lx, ly, thl_q);
			if (flags_q[3]) b[7:4] = b[7:4] & ~map4(rx, ry, thr_q);
		end
	end

	jcd_axis u_lx (.clk, .adv, .remap_en(rmp), .analog, .v(lx),
		.mn(rl_q[7:0]), .ctr(rl_q[15:8]), .mx(rl_q[23:16]), .dz(dzl_q), .result(ox[0]));
	jcd_axis u_ly (.clk, .adv, .remap_en(rmp), .analog, .v(ly),
		.mn(rl_q[31:24]), .ctr(rl_q[39:32]), .mx(rl_q[47:40]), .dz(dzl_q), .result(ox[1]));
	jcd_axis u_rx (.clk, .adv, .remap_en(rmp), .analog, .v(rx),
		.mn(rr_q[7:0]), .ctr(rr_q[15:8]), .mx(rr_q[23:16]), .dz(dzr_q), .result(ox[2]));
	jcd_axis u_ry (.clk, .adv, .remap_en(rmp), .analog, .v(ry),
		.mn(rr_q[31:24]), .ctr(rr_q[39:32]), .mx(rr_q[47:40]), .dz(dzr_q), .result(ox[3]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= '0;
			m_axis_tvalid <= 1'b0;
		end else if (adv) begin
			vld_s1 <= {vld_s1[Depth-2:0], s_axis_tvalid};
			m_axis_tvalid <= vld_s1[Depth-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			btn_s1[0] <= b;
			for (int i = 1; i < Depth; i++) btn_s1[i] <= btn_s1[i-1];
			m_axis_tdata <= {btn_s1[Depth-1], ox[3], ox[2], ox[1], ox[0]};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output valid dropped under stall");
	assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_s1))
		else $error("pipe moved during stall");
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!m_axis_tvalid || m_axis_tready))
		else $error("ready mismatch");

endmodule

// File: hdl/jcd_axis.sv
// One axis of remap and deadzone, pipelined with a restoring divider one bit per stage.
// Depends on jcd_pkg.
module jcd_axis import jcd_pkg::*; (
	input logic clk,
	input logic adv,
	input logic remap_en,
	input logic analog,
	input logic [7:0] v,
	input logic [7:0] mn,
	input logic [7:0] ctr,
	input logic [7:0] mx,
	input logic [7:0] dz,
	output logic [7:0] result
);

	localparam int NSt = DivW + 1;

	div_t st_s1 [NSt];
	logic [7:0] raw_s1 [NSt];
	logic act_s1 [NSt];
	logic rmp_s1 [NSt];
	logic [7:0] dz_s1 [NSt];

	logic signed [9:0] n0;
	logic signed [9:0] d0;
	logic upper0;
	div_t first;

	always_comb begin
		upper0 = (v >= ctr);
		n0 = upper0 ? ($signed({2'b00, v}) - $signed({2'b00, ctr}))
			: ($signed({2'b00, v}) - $signed({2'b00, mn}));
		d0 = upper0 ? ($signed({2'b00, mx}) - $signed({2'b00, ctr}))
			: ($signed({2'b00, ctr}) - $signed({2'b00, mn}));
		if (d0 < 0) begin
			n0 = -n0;
			d0 = -d0;
		end
		first = '0;
		first.upper = upper0;
		first.force_zero = (n0 <= 0) && (d0 != 0);
		first.force_max = (d0 == 0) ? (n0 >= 0) : (n0 >= d0);
		if (d0 == 0 && n0 < 0) first.force_zero = 1'b1;
		// numerator times 127, fits 16 bits
		first.rem = 16'((n0[8:0] << 7) - {7'd0, n0[8:0]});
		first.den = {7'd0, d0[8:0]};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s1[0] <= first;
			raw_s1[0] <= v;
			act_s1[0] <= analog;
			rmp_s1[0] <= remap_en;
			dz_s1[0] <= dz;
		end
	end

	for (genvar k = 1; k < NSt; k++) begin : g_div
		localparam int Sh = DivW - k;
		logic [22:0] trial;
		div_t nxt;
		always_comb begin
			nxt = st_s1[k-1];
			trial = {7'd0, st_s1[k-1].den} << Sh;
			if ({7'd0, st_s1[k-1].rem} >= trial) begin
				nxt.rem = 16'({7'd0, st_s1[k-1].rem} - trial);
				nxt.quo[Sh] = 1'b1;
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				st_s1[k] <= nxt;
				raw_s1[k] <= raw_s1[k-1];
				act_s1[k] <= act_s1[k-1];
				rmp_s1[k] <= rmp_s1[k-1];
				dz_s1[k] <= dz_s1[k-1];
			end
		end
	end

	logic [6:0] r;
	logic [7:0] a;
	logic signed [9:0] ax;
	logic signed [9:0] dzs;

	always_comb begin
		r = st_s1[NSt-1].force_zero ? 7'd0
			: (st_s1[NSt-1].force_max ? 7'd127 : st_s1[NSt-1].quo);
		a = rmp_s1[NSt-1] ? {st_s1[NSt-1].upper, r} : raw_s1[NSt-1];
		ax = $signed({2'b00, a});
		dzs = $signed({2'b00, dz_s1[NSt-1]});
		result = raw_s1[NSt-1];
		if (act_s1[NSt-1]) begin
			result = a;
			if (dzs != 0 && ax > 10'sd127 - dzs && ax < 10'sd128 + dzs) result = 8'h7f;
		end
	end

endmodule

// File: sim/joystick_calibrate_deadzone_test.sv
// Self-checking bench for joystick_calibrate_deadzone: remap, deadzone and button mapping.
// Drives random samples under several register settings, predicts each result in-bench.
// Depends on jcd_pkg and the block RTL.
`timescale 1ns / 100ps
module joystick_calibrate_deadzone_test;
	import jcd_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [47:0] cfg_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [39:0] s_axis_tdata = '0; // lx, ly, rx, ry, buttons
	logic [1:0] s_axis_tuser = '0; // mode
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata; // lx, ly, rx, ry, buttons

	joystick_calibrate_deadzone DUT (.*);

	always #1 clk = ~clk;

	logic [3:0] flags_q;
	logic [47:0] remap_l_q, remap_r_q;
	logic [7:0] dz_l_q, dz_r_q, th_l_q, th_r_q;

	logic [39:0] sample_q[$];
	int errors = 0, sent = 0, checked = 0, cycles = 0;
	bit idle_src = 1'b1, idle_snk = 1'b1;

	function automatic logic [7:0] scale127(int n, int d);
		if (d == 0) return (n < 0) ? 8'd0 : 8'd127;
		if (d < 0) begin
			n = -n;
			d = -d;
		end
		if (n <= 0) return 8'd0;
		if (n >= d) return 8'd127;
		return 8'((127 * n) / d);
	endfunction

	function automatic logic [7:0] remap_axis(logic [7:0] v, logic [23:0] cfg);
		int mn, c, mx, x;
		mn = cfg[7:0];
		c = cfg[15:8];
		mx = cfg[23:16];
		x = v;
		if (x < c) return scale127(x - mn, c - mn);
		return 8'h80 + scale127(x - c, mx - c);
	endfunction

	function automatic logic [7:0] snap_center(logic [7:0] a, logic [7:0] dz);
		int x, d;
		x = a;
		d = dz;
		if (d != 0 && x > 127 - d && x < 128 + d) return 8'h7F;
		return a;
	endfunction

	function automatic logic [7:0] press_dirs(logic [7:0] b, logic [7:0] xa, logic [7:0] ya,
			logic [7:0] th, int base);
		int x, y, t;
		x = xa;
		y = ya;
		t = th;
		if (x < 127 - t) b[base] = 1'b0;
		if (x > 128 + t) b[base + 1] = 1'b0;
		if (y < 127 - t) b[base + 2] = 1'b0;
		if (y > 128 + t) b[base + 3] = 1'b0;
		return b;
	endfunction

	function automatic logic [39:0] condition(logic [1:0] mode, logic [39:0] d);
		logic [7:0] lx, ly, rx, ry, b;
		{b, ry, rx, ly, lx} = d;
		if (flags_q[0]) begin
			if (mode == MODE_ANALOG || mode == MODE_ANALOG_FULL) begin
				if (flags_q[1]) begin
					lx = remap_axis(lx, remap_l_q[23:0]);
					ly = remap_axis(ly, remap_l_q[47:24]);
					rx = remap_axis(rx, remap_r_q[23:0]);
					ry = remap_axis(ry, remap_r_q[47:24]);
				end
				lx = snap_center(lx, dz_l_q);
				ly = snap_center(ly, dz_l_q);
				rx = snap_center(rx, dz_r_q);
				ry = snap_center(ry, dz_r_q);
			end else if (mode == MODE_DIGITAL) begin
				if (flags_q[2]) b = press_dirs(b, lx, ly, th_l_q, 0);
				if (flags_q[3]) b = press_dirs(b, rx, ry, th_r_q, 4);
			end
		end
		return {b, ry, rx, ly, lx};
	endfunction

	task automatic write_reg(reg_idx_t idx, logic [47:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_FLAGS: flags_q = val[3:0];
			REG_REMAP_L: remap_l_q = val;
			REG_REMAP_R: remap_r_q = val;
			REG_DZ_L: dz_l_q = val[7:0];
			REG_DZ_R: dz_r_q = val[7:0];
			REG_TH_L: th_l_q = val[7:0];
			default: th_r_q = val[7:0];
		endcase
		@(posedge clk);
	endtask

	task automatic send_sample(logic [1:0] mode, logic [39:0] d);
		while (idle_src && $urandom_range(99) < 10) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= mode;
		s_axis_tdata <= d;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sample_q.push_back(condition(mode, d));
		sent++;
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sample_q.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	function automatic logic [47:0] rand_remap();
		return 48'({$urandom, $urandom});
	endfunction

	function automatic logic [39:0] rand_sample();
		logic [39:0] d;
		d = 40'({$urandom, $urandom});
		for (int i = 0; i < 4; i++)
			if ($urandom_range(3) == 0) d[i*8 +: 8] = 8'd120 + 8'($urandom_range(15));
		return d;
	endfunction

	task automatic run_random(int n);
		for (int i = 0; i < n; i++) send_sample(2'($urandom), rand_sample());
	endtask

	task automatic test_passthrough();
		send_sample(MODE_ANALOG, 40'h00_00_00_00_00);
		send_sample(MODE_DIGITAL, 40'hFF_FF_FF_FF_FF);
		run_random(40);
		drain();
	endtask

	task automatic test_directed();
		write_reg(REG_FLAGS, 48'hF);
		write_reg(REG_REMAP_L, 48'hF0_80_10_FF_7F_00);
		write_reg(REG_REMAP_R, 48'h10_80_F0_40_40_40);
		write_reg(REG_DZ_L, 48'd10);
		write_reg(REG_DZ_R, 48'd255);
		write_reg(REG_TH_L, 48'd20);
		write_reg(REG_TH_R, 48'd0);
		// extremes, centre, each mode; inverted and zero-span remaps
		for (int m = 0; m < 4; m++) begin
			send_sample(2'(m), 40'hFF_00_00_00_00);
			send_sample(2'(m), 40'h00_FF_FF_FF_FF);
			send_sample(2'(m), 40'h55_7F_80_7F_80);
			send_sample(2'(m), 40'hAA_40_C0_6A_95);
			send_sample(2'(m), 40'h0F_81_7E_10_F0);
		end
		drain();
	endtask

	task automatic test_settings();
		logic [7:0] ext[4] = '{8'd0, 8'd1, 8'd128, 8'd255};
		for (int k = 0; k < 7; k++) begin
			write_reg(REG_FLAGS, (k < 2) ? 48'h3 : 48'($urandom_range(15) | 1));
			write_reg(REG_REMAP_L, (k == 0) ? 48'h0 : (k == 1) ? 48'hFF_FF_FF_FF_FF_FF :
				(k == 2) ? 48'hFF_80_00_FF_80_00 : rand_remap());
			write_reg(REG_REMAP_R, (k == 2) ? 48'hFF_80_00_FF_80_00 : rand_remap());
			write_reg(REG_DZ_L, 48'(ext[k % 4]));
			write_reg(REG_DZ_R, 48'(ext[(k + 1) % 4]));
			write_reg(REG_TH_L, (k < 4) ? 48'(ext[k]) : 48'($urandom_range(60)));
			write_reg(REG_TH_R, (k < 4) ? 48'(ext[3 - k]) : 48'($urandom_range(60)));
			if (k == 5) idle_src = 1'b0;
			if (k == 6) idle_snk = 1'b0;
			run_random(100);
			drain();
			idle_src = 1'b1;
			idle_snk = 1'b1;
		end
	endtask

	always @(posedge clk) begin
		logic [39:0] want;
		cycles++;
		if (cycles > 200000) begin
			$display("joystick_calibrate_deadzone verification failed");
			$finish;
		end
		if (m_axis_tvalid && m_axis_tready) begin
			if (sample_q.size() == 0) begin
				$display("%0t: unexpected transfer, actual %h", $time, m_axis_tdata);
				errors++;
			end else begin
				want = sample_q.pop_front();
				checked++;
				for (int f = 0; f < 5; f++)
					if (want[f*8 +: 8] !== m_axis_tdata[f*8 +: 8]) begin
						$display("%0t: field %0d expected %h actual %h", $time, f,
							want[f*8 +: 8], m_axis_tdata[f*8 +: 8]);
						errors++;
					end
			end
		end
		m_axis_tready <= !(idle_snk && $urandom_range(99) < 10);
	end

	initial begin
		{flags_q, remap_l_q, remap_r_q, dz_l_q, dz_r_q, th_l_q, th_r_q} = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_passthrough();
		test_directed();
		test_settings();
		if (sample_q.size() != 0) errors++;
		$display("Sent %0d samples over all modes and 9 register settings, checked %0d.",
			sent, checked);
		if (errors == 0)
			$display("joystick_calibrate_deadzone verification clean");
		else
			$display("joystick_calibrate_deadzone verification failed");
		$finish;
	end
endmodule
